>>> rtl/sha256_byte_stream_hasher_macros.svh
// Assertion helpers for the RTL that checks itself.
`ifndef SHA256_BYTE_STREAM_HASHER_MACROS_SVH
`define SHA256_BYTE_STREAM_HASHER_MACROS_SVH

// Same-cycle implication, sampled on i_clk, off during reset.
`define SBH_ASSERT_NOW(label, cond_a, cond_c) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond_a) |-> (cond_c)) \
        else $error("sha256 hasher check failed");

// Next-cycle implication, sampled on i_clk, off during reset.
`define SBH_ASSERT_NEXT(label, cond_a, cond_c) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond_a) |=> (cond_c)) \
        else $error("sha256 hasher check failed");

`endif

>>> rtl/sha256bsh_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package sha256bsh_pkg;

    localparam int LEN_BITS_DEF = 61;
    localparam int BLOCK_BYTES  = 64;
    localparam int LEN_POS      = 56;
    localparam int ROUNDS       = 64;
    localparam int DIGEST_WORDS = 4;

    localparam logic [7:0] PAD_BYTE  = 8'h80;
    localparam logic [7:0] ZERO_BYTE = 8'h00;

    localparam logic [255:0] INIT_HASH = {
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] ROUND_K [ROUNDS] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    typedef struct packed {
        logic       shift_en;
        logic [7:0] shift_byte;
        logic       start;
        logic       hash_init;
    } t_core_ctl;

    typedef struct packed {
        logic busy;
        logic done;
    } t_core_st;

endpackage

`default_nettype wire

>>> rtl/sha256bsh_core.sv
`timescale 1ns / 1ps
`default_nettype none

module sha256bsh_core
    import sha256bsh_pkg::*;
(
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire t_core_ctl    i_ctl,
    output t_core_st          o_st,
    output logic [255:0]      o_hash
);

    logic [0:7][31:0] r_hash;
    logic [0:7][31:0] r_vars;
    logic [511:0]     r_buf;
    logic [5:0]       r_round;
    logic             r_run;
    logic             r_fin;

    logic [31:0] w0, w1, w9, w14, w16;
    logic [31:0] t1, t2;
    logic [31:0] va, vb, vc, vd, ve, vf, vg, vh;

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

    assign w0  = r_buf[511:480];
    assign w1  = r_buf[479:448];
    assign w9  = r_buf[223:192];
    assign w14 = r_buf[63:32];

    assign w16 = (rotr(w14, 17) ^ rotr(w14, 19) ^ (w14 >> 10)) + w9 +
                 (rotr(w1, 7) ^ rotr(w1, 18) ^ (w1 >> 3)) + w0;

    assign va = r_vars[0];
    assign vb = r_vars[1];
    assign vc = r_vars[2];
    assign vd = r_vars[3];
    assign ve = r_vars[4];
    assign vf = r_vars[5];
    assign vg = r_vars[6];
    assign vh = r_vars[7];

    assign t1 = vh + (rotr(ve, 6) ^ rotr(ve, 11) ^ rotr(ve, 25)) +
                ((ve & vf) ^ (~ve & vg)) + ROUND_K[r_round] + w0;
    assign t2 = (rotr(va, 2) ^ rotr(va, 13) ^ rotr(va, 22)) +
                ((va & vb) ^ (va & vc) ^ (vb & vc));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run   <= 1'b0;
            r_fin   <= 1'b0;
            r_round <= '0;
            r_hash  <= INIT_HASH;
        end else begin
            if (i_ctl.hash_init) begin
                r_hash <= INIT_HASH;
            end
            if (i_ctl.start) begin
                r_run   <= 1'b1;
                r_round <= '0;
            end else if (r_run) begin
                r_round <= r_round + 6'd1;
                if (r_round == 6'(ROUNDS - 1)) begin
                    r_run <= 1'b0;
                end
            end
            r_fin <= r_run && !i_ctl.start && (r_round == 6'(ROUNDS - 1));
            if (r_fin) begin
                for (int i = 0; i < 8; i++) begin
                    r_hash[i] <= r_hash[i] + r_vars[i];
                end
            end
        end
    end

    // message buffer doubles as the rolling schedule window
    always_ff @(posedge i_clk) begin
        if (i_ctl.shift_en) begin
            r_buf <= {r_buf[503:0], i_ctl.shift_byte};
        end else if (r_run) begin
            r_buf <= {r_buf[479:0], w16};
        end
        if (i_ctl.start) begin
            r_vars <= r_hash;
        end else if (r_run) begin
            r_vars <= {t1 + t2, va, vb, vc, vd + t1, ve, vf, vg};
        end
    end

    assign o_st.busy = r_run | r_fin;
    assign o_st.done = r_fin;
    assign o_hash    = r_hash;

endmodule

`default_nettype wire

>>> rtl/sha256_byte_stream_hasher.sv
// One byte beat per cycle is taken while the block is idle, not padding, writing the length or compressing.
// The 64th byte of a block holds off input while the core runs its rounds and folds the result in.
// A last beat pads one byte per cycle, pausing while a block compresses, and compresses
// once or twice; the first digest beat is held back while the previous digest drains.
// Four output beats follow and drain while input resumes.
// Synchronous active-low reset loads the initial hash values and empties the message.
`timescale 1ns / 1ps
`default_nettype none
`include "sha256_byte_stream_hasher_macros.svh"

module sha256_byte_stream_hasher
    import sha256bsh_pkg::*;
#(
    parameter int LENGTH_COUNTER_BITS = LEN_BITS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [7:0]  i_s_tdata,   // [7:0] data_byte
    input  wire logic        i_s_tuser,   // [0] has_byte
    input  wire logic        i_s_tlast,   // last_byte
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [63:0]      o_m_tdata,   // [63:0] digest_word
    output logic [1:0]       o_m_tuser,   // [1:0] word_index
    output logic             o_m_tlast    // last_word
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_PAD  = 3'd1;
    localparam logic [2:0] S_LEN  = 3'd2;
    localparam logic [2:0] S_COMP = 3'd3;
    localparam logic [2:0] S_FIN  = 3'd4;

    localparam logic [5:0] POS_LAST = 6'(BLOCK_BYTES - 1);
    localparam logic [5:0] POS_LEN  = 6'(LEN_POS);
    localparam logic [1:0] IDX_LAST = 2'(DIGEST_WORDS - 1);

    logic [2:0]                     r_state;
    logic [2:0]                     r_ret;
    logic [5:0]                     r_fill;
    logic [LENGTH_COUNTER_BITS-1:0] r_count;
    logic                           r_first;
    logic                           r_out_busy;
    logic [1:0]                     r_widx;
    logic [255:0]                   r_dig;

    t_core_ctl    core_ctl;
    t_core_st     core_st;
    logic [255:0] core_hash;
    logic [63:0]  len_bits;
    logic         s_acc;
    logic         m_acc;
    logic         pad_done;

    sha256bsh_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (core_ctl),
        .o_st    (core_st),
        .o_hash  (core_hash)
    );

    assign o_s_tready = (r_state == S_IDLE);
    assign s_acc      = i_s_tvalid && o_s_tready;
    assign m_acc      = o_m_tvalid && i_m_tready;
    assign len_bits   = 64'({r_count, 3'b000});
    assign pad_done   = !r_first && (r_fill == POS_LEN);

    always_comb begin
        core_ctl = '0;
        unique case (r_state)
            S_IDLE: begin
                if (s_acc && i_s_tuser) begin
                    core_ctl.shift_en   = 1'b1;
                    core_ctl.shift_byte = i_s_tdata;
                    core_ctl.start      = (r_fill == POS_LAST);
                end
            end
            S_PAD: begin
                if (!pad_done) begin
                    core_ctl.shift_en   = 1'b1;
                    core_ctl.shift_byte = r_first ? PAD_BYTE : ZERO_BYTE;
                    core_ctl.start      = (r_fill == POS_LAST);
                end
            end
            S_LEN: begin
                core_ctl.shift_en   = 1'b1;
                core_ctl.shift_byte = len_bits[{~r_fill[2:0], 3'b000} +: 8];
                core_ctl.start      = (r_fill == POS_LAST);
            end
            S_FIN: begin
                core_ctl.hash_init = !r_out_busy;
            end
            default: begin
                core_ctl = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_ret      <= S_IDLE;
            r_fill     <= '0;
            r_count    <= '0;
            r_first    <= 1'b0;
            r_out_busy <= 1'b0;
            r_widx     <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (s_acc) begin
                        if (i_s_tlast) begin
                            r_first <= 1'b1;
                        end
                        if (i_s_tuser) begin
                            r_fill  <= r_fill + 6'd1;
                            r_count <= r_count + LENGTH_COUNTER_BITS'(1);
                        end
                        if (i_s_tuser && r_fill == POS_LAST) begin
                            r_state <= S_COMP;
                            r_ret   <= i_s_tlast ? S_PAD : S_IDLE;
                        end else if (i_s_tlast) begin
                            r_state <= S_PAD;
                        end
                    end
                end
                S_PAD: begin
                    if (pad_done) begin
                        r_state <= S_LEN;
                    end else begin
                        r_fill  <= r_fill + 6'd1;
                        r_first <= 1'b0;
                        if (r_fill == POS_LAST) begin
                            r_state <= S_COMP;
                            r_ret   <= S_PAD;
                        end
                    end
                end
                S_LEN: begin
                    r_fill <= r_fill + 6'd1;
                    if (r_fill == POS_LAST) begin
                        r_state <= S_COMP;
                        r_ret   <= S_FIN;
                    end
                end
                S_COMP: begin
                    if (core_st.done) begin
                        r_state <= r_ret;
                    end
                end
                S_FIN: begin
                    if (!r_out_busy) begin
                        r_out_busy <= 1'b1;
                        r_widx     <= '0;
                        r_count    <= '0;
                        r_state    <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
            if (m_acc) begin
                r_widx <= r_widx + 2'd1;
                if (r_widx == IDX_LAST) begin
                    r_out_busy <= 1'b0;
                end
            end
        end
    end

    // hold the digest, advance one word per output beat
    always_ff @(posedge i_clk) begin
        if (r_state == S_FIN && !r_out_busy) begin
            r_dig <= core_hash;
        end else if (m_acc) begin
            r_dig <= {r_dig[191:0], 64'd0};
        end
    end

    assign o_m_tvalid = r_out_busy;
    assign o_m_tdata  = r_dig[255:192];
    assign o_m_tuser  = r_widx;
    assign o_m_tlast  = (r_widx == IDX_LAST);

    `SBH_ASSERT_NOW(a_idle_core_quiet, r_state == S_IDLE || r_state == S_FIN, !core_st.busy)
    `SBH_ASSERT_NOW(a_done_in_comp, core_st.done, r_state == S_COMP)
    `SBH_ASSERT_NOW(a_len_tail, r_state == S_LEN, r_fill[5:3] == 3'b111)
    `SBH_ASSERT_NEXT(a_drain_ends, m_acc && r_widx == IDX_LAST, !o_m_tvalid)

endmodule

`default_nettype wire

>>> tb/sha256_byte_stream_hasher_test.sv
`timescale 1ns / 1ps

module sha256_byte_stream_hasher_test;
    import sha256bsh_pkg::*;

    localparam int CNT_W = LEN_BITS_DEF;
    localparam int HOLD_CYCLES = 400;
    localparam int DRAIN_CYCLES = 250;

    localparam logic [31:0] SHA_IV [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] SHA_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    typedef struct packed {
        logic       has;
        logic [7:0] dat;
        logic       fin;
    } beat_t;

    typedef struct packed {
        logic [63:0] word;
        logic [1:0]  idx;
        logic        fin;
    } digest_beat_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_valid = 1'b0;
    logic [7:0]  s_data = 8'h00;
    logic        s_has = 1'b0;
    logic        s_last = 1'b0;
    logic        m_ready = 1'b0;
    logic        o_s_tready;
    logic        o_m_tvalid;
    logic [63:0] o_m_tdata;
    logic [1:0]  o_m_tuser;
    logic        o_m_tlast;

    beat_t        pending_beats [$];
    digest_beat_t digest_q [$];

    logic [31:0]      hash_state [8];
    logic [7:0]       blk_buf [64];
    logic [CNT_W-1:0] msg_bytes;

    int   send_idle = 0;
    int   recv_stall = 0;
    logic hold_req = 1'b0;
    logic rx_hold = 1'b0;
    int   err_count = 0;

    sha256_byte_stream_hasher DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_valid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (s_data),   // [7:0] data_byte
        .i_s_tuser  (s_has),    // [0] has_byte
        .i_s_tlast  (s_last),   // last_byte
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (m_ready),
        .o_m_tdata  (o_m_tdata), // [63:0] digest_word
        .o_m_tuser  (o_m_tuser), // [1:0] word_index
        .o_m_tlast  (o_m_tlast)  // last_word
    );

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    task automatic sha_compress();
        logic [31:0] w [64];
        logic [31:0] a, b, c, d, e, f, g, h, t1, t2, s0, s1;
        for (int i = 0; i < 16; i++) begin
            w[i] = {blk_buf[4*i], blk_buf[4*i+1], blk_buf[4*i+2], blk_buf[4*i+3]};
        end
        for (int i = 16; i < 64; i++) begin
            s0 = rotr(w[i-15], 7) ^ rotr(w[i-15], 18) ^ (w[i-15] >> 3);
            s1 = rotr(w[i-2], 17) ^ rotr(w[i-2], 19) ^ (w[i-2] >> 10);
            w[i] = s1 + w[i-7] + s0 + w[i-16];
        end
        a = hash_state[0]; b = hash_state[1]; c = hash_state[2]; d = hash_state[3];
        e = hash_state[4]; f = hash_state[5]; g = hash_state[6]; h = hash_state[7];
        for (int i = 0; i < 64; i++) begin
            t1 = h + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & f) ^ (~e & g))
                 + SHA_K[i] + w[i];
            t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
            h = g; g = f; f = e; e = d + t1;
            d = c; c = b; b = a; a = t1 + t2;
        end
        hash_state[0] += a; hash_state[1] += b; hash_state[2] += c; hash_state[3] += d;
        hash_state[4] += e; hash_state[5] += f; hash_state[6] += g; hash_state[7] += h;
    endtask

    task automatic start_message();
        foreach (hash_state[i]) hash_state[i] = SHA_IV[i];
        msg_bytes = '0;
    endtask

    task automatic hash_beat(input beat_t bt);
        int           pos;
        logic [63:0]  bit_len;
        digest_beat_t dw;
        if (bt.has) begin
            pos = int'(msg_bytes[5:0]);
            blk_buf[pos] = bt.dat;
            msg_bytes = msg_bytes + CNT_W'(1);
            if (pos == 63) sha_compress();
        end
        if (bt.fin) begin
            pos = int'(msg_bytes[5:0]);
            blk_buf[pos] = 8'h80;
            for (int j = pos + 1; j < 64; j++) blk_buf[j] = 8'h00;
            if (pos >= 56) begin
                sha_compress();
                foreach (blk_buf[j]) blk_buf[j] = 8'h00;
            end
            bit_len = 64'(msg_bytes) << 3;
            for (int j = 0; j < 8; j++) blk_buf[63-j] = bit_len[8*j +: 8];
            sha_compress();
            for (int k = 0; k < 4; k++) begin
                dw.word = {hash_state[2*k], hash_state[2*k+1]};
                dw.idx = 2'(k);
                dw.fin = (k == 3);
                digest_q.push_back(dw);
            end
            start_message();
        end
    endtask

    task automatic queue_beat(input logic has, input logic [7:0] dat, input logic fin);
        beat_t bt;
        bt.has = has;
        bt.dat = dat;
        bt.fin = fin;
        pending_beats.push_back(bt);
    endtask

    task automatic queue_message(input int len);
        logic bare;
        bare = (len == 0) || ($urandom_range(3) == 0);
        for (int i = 0; i < len; i++) begin
            if ($urandom_range(9) == 0) queue_beat(1'b0, 8'($urandom_range(255)), 1'b0);
            queue_beat(1'b1, 8'($urandom_range(255)), !bare && (i == len - 1));
        end
        if (bare) queue_beat(1'b0, 8'($urandom_range(255)), 1'b1);
    endtask

    task automatic queue_random(input int n_beats);
        int len;
        while (pending_beats.size() < n_beats) begin
            len = $urandom_range(12);
            queue_message(len);
        end
    endtask

    task automatic wait_drained();
        while (pending_beats.size() != 0 || s_valid || digest_q.size() != 0)
            @(negedge i_clk);
    endtask

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && o_s_tready) hash_beat('{s_has, s_data, s_last});
            if (!s_valid || o_s_tready) begin
                if (pending_beats.size() != 0 && $urandom_range(99) >= send_idle) begin
                    beat_t bt;
                    bt = pending_beats.pop_front();
                    s_valid <= 1'b1;
                    s_has <= bt.has;
                    s_data <= bt.dat;
                    s_last <= bt.fin;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_ready <= 1'b0;
        end else begin
            if (o_m_tvalid && m_ready) begin
                if (digest_q.size() == 0) begin
                    $error("unexpected digest beat: word %h index %0d", o_m_tdata, o_m_tuser);
                    err_count++;
                end else begin
                    digest_beat_t dw;
                    dw = digest_q.pop_front();
                    if (o_m_tdata !== dw.word) begin
                        $error("digest_word: expected %h, got %h", dw.word, o_m_tdata);
                        err_count++;
                    end
                    if (o_m_tuser !== dw.idx) begin
                        $error("word_index: expected %0d, got %0d", dw.idx, o_m_tuser);
                        err_count++;
                    end
                    if (o_m_tlast !== dw.fin) begin
                        $error("last_word: expected %0b, got %0b", dw.fin, o_m_tlast);
                        err_count++;
                    end
                end
            end
            m_ready <= !rx_hold && ($urandom_range(99) >= recv_stall);
        end
    end

    // hold off the output side so the block backs up into its input
    initial begin
        wait (hold_req);
        @(posedge i_clk);
        rx_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        rx_hold <= 1'b0;
    end

    initial begin
        start_message();
        foreach (blk_buf[i]) blk_buf[i] = 8'h00;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        @(negedge i_clk);
        queue_beat(1'b0, 8'h00, 1'b0);
        queue_beat(1'b0, 8'h00, 1'b1);
        queue_beat(1'b1, 8'h61, 1'b0);
        queue_beat(1'b1, 8'h62, 1'b0);
        queue_beat(1'b0, 8'hff, 1'b0);
        queue_beat(1'b1, 8'h63, 1'b1);
        queue_beat(1'b1, 8'hff, 1'b1);
        queue_beat(1'b1, 8'h00, 1'b0);
        queue_beat(1'b0, 8'hff, 1'b1);
        queue_beat(1'b0, 8'hff, 1'b1);
        wait_drained();

        @(negedge i_clk);
        queue_message(56);
        queue_message(64);
        wait_drained();

        @(negedge i_clk);
        hold_req = 1'b1;
        for (int i = 0; i < 5; i++) queue_message($urandom_range(3));
        wait_drained();

        @(negedge i_clk);
        send_idle = 83;
        queue_random(8);
        wait_drained();

        @(negedge i_clk);
        send_idle = 0;
        recv_stall = 83;
        queue_random(8);
        wait_drained();

        @(negedge i_clk);
        send_idle = 27;
        recv_stall = 27;
        queue_random(8);
        wait_drained();

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (err_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule

>>> filelist.f
+incdir+rtl
rtl/sha256bsh_pkg.sv
rtl/sha256bsh_core.sv
rtl/sha256_byte_stream_hasher.sv
tb/sha256_byte_stream_hasher_test.sv
